// File: design/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants for the RPN stack evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 64;

    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_MOD  = 3'd5;
    localparam logic [2:0] OP_MIN  = 3'd6;
    localparam logic [2:0] OP_MAX  = 3'd7;

    localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [63:0] value;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] result;
        logic               divided_by_zero;
        logic               stack_overflowed;
        logic               saturated;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;   // capture input transaction
        logic rd_b;        // read top entry
        logic rd_a;        // read entry below top
        logic push;        // write value at count
        logic alu_start;   // start an operation on a and b
        logic writeback;   // pop one and write the result
        logic emit;        // load output register and clear stack
        logic skip_div;    // zero divisor: write 0 and flag
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       last;
        logic       full;
        logic       two_plus;
        logic       b_zero;
        logic       alu_done;
        logic       out_busy;
    } dp_sts_t;

endpackage

// File: design/rpn_divider.sv
// ----------------------------------------------------------------------------
// rpn_divider
// Radix-2 restoring divider for Q32.32 divide and remainder, one bit a cycle.
// ----------------------------------------------------------------------------
module rpn_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic        is_mod,
    input  logic [63:0] a_mag,
    input  logic [63:0] b_mag,
    output logic        done,
    output logic [63:0] quot,
    output logic        big,
    output logic [63:0] rem
);

    logic        busy_reg, busy_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] num_reg, num_next;
    logic [63:0] den_reg, den_next;
    logic        big_reg, big_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;
    logic [64:0] diff;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        big_next  = big_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[63:0], num_reg[63]};
        diff      = shifted - {1'b0, den_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = is_mod ? 7'd64 : 7'd96;
            rem_next  = '0;
            q_next    = '0;
            num_next  = a_mag;
            den_next  = b_mag;
            big_next  = 1'b0;
        end else if (busy_reg) begin
            num_next = {num_reg[62:0], 1'b0};
            if (!diff[64]) begin
                rem_next = diff;
            end else begin
                rem_next = shifted;
            end
            if (q_reg[63]) begin
                big_next = 1'b1;
            end
            q_next   = {q_reg[62:0], ~diff[64]};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        num_reg <= num_next;
        den_reg <= den_next;
        big_reg <= big_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign big  = big_reg;
    assign rem  = rem_reg[63:0];

endmodule

// File: design/rpn_datapath.sv
// ----------------------------------------------------------------------------
// rpn_datapath
// Operand stack, arithmetic units, sticky flags and the output register.
// ----------------------------------------------------------------------------
module rpn_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  rpn_pkg::in_item_t  in_item,
    input  rpn_pkg::dp_cmd_t   cmd,
    output rpn_pkg::dp_sts_t   sts,
    output rpn_pkg::out_item_t out_item,
    output logic               out_valid,
    input  logic               out_ready
);

    logic [63:0] mem [rpn_pkg::STACK_DEPTH];
    logic [63:0] rd_data_reg;

    rpn_pkg::in_item_t           item_reg;
    logic [rpn_pkg::CNT_W-1:0]   cnt_reg;
    logic [2:0]                  flags_reg, flags_next;
    logic [63:0]                 a_reg, b_reg;
    logic                        lda_reg;
    logic [63:0]                 res_reg, res_next;
    logic                        res_ok_reg, res_ok_next;
    logic [1:0]                  mul_ph_reg;
    logic                        mul_busy_reg;
    logic [63:0]                 am_reg, bm_reg;
    logic [63:0]                 p00_reg, p01_reg, p10_reg, p11_reg;
    logic                        ovalid_reg;
    rpn_pkg::out_item_t          oitem_reg;

    logic [rpn_pkg::PTR_W-1:0]   rd_addr;
    logic [rpn_pkg::PTR_W-1:0]   wr_addr;
    logic                        wr_en;
    logic [63:0]                 wr_data;
    logic [63:0]                 a_mag, b_mag;
    logic                        neg_res;
    logic                        div_done;
    logic [63:0]                 div_q, div_r;
    logic                        div_big;
    logic [63:0]                 sum, dif;
    logic [64:0]                 mid;
    logic [63:0]                 hi;
    logic [63:0]                 mag;
    logic                        mbig;
    logic                        a_lt_b;

    assign a_mag   = a_reg[63] ? (64'd0 - a_reg) : a_reg;
    assign b_mag   = b_reg[63] ? (64'd0 - b_reg) : b_reg;
    assign neg_res = a_reg[63] ^ b_reg[63];
    assign a_lt_b  = $signed(a_reg) < $signed(b_reg);

    rpn_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.alu_start
                  && (item_reg.op == rpn_pkg::OP_DIV || item_reg.op == rpn_pkg::OP_MOD)),
        .is_mod  (item_reg.op == rpn_pkg::OP_MOD),
        .a_mag   (a_mag),
        .b_mag   (b_mag),
        .done    (div_done),
        .quot    (div_q),
        .big     (div_big),
        .rem     (div_r)
    );

    always_comb begin
        rd_addr = '0;
        if (cmd.rd_b) begin
            rd_addr = rpn_pkg::PTR_W'(cnt_reg - rpn_pkg::CNT_W'(1));
        end else if (cmd.rd_a) begin
            rd_addr = rpn_pkg::PTR_W'(cnt_reg - rpn_pkg::CNT_W'(2));
        end
        wr_en   = (cmd.push && cnt_reg != rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH))
                  || cmd.writeback;
        wr_addr = cmd.push ? rpn_pkg::PTR_W'(cnt_reg)
                           : rpn_pkg::PTR_W'(cnt_reg - rpn_pkg::CNT_W'(2));
        wr_data = cmd.push ? item_reg.value : res_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Multiply: partial products, then combine, then clamp.
    assign mid = {33'd0, p00_reg[63:32]} + {33'd0, p01_reg[31:0]} + {33'd0, p10_reg[31:0]};
    assign hi  = p11_reg + {32'd0, p01_reg[63:32]} + {32'd0, p10_reg[63:32]}
                 + {31'd0, mid[64:32]};
    assign mag  = {hi[31:0], mid[31:0]};
    assign mbig = hi[63:32] != 32'd0;

    always_comb begin
        sum         = a_reg + b_reg;
        dif         = a_reg - b_reg;
        res_next    = res_reg;
        res_ok_next = 1'b0;
        flags_next  = flags_reg;
        if (cmd.alu_start) begin
            case (item_reg.op)
                rpn_pkg::OP_ADD: begin
                    res_ok_next = 1'b1;
                    if (a_reg[63] == b_reg[63] && sum[63] != a_reg[63]) begin
                        flags_next[2] = 1'b1;
                        res_next = a_reg[63] ? rpn_pkg::MIN_NEG : rpn_pkg::MAX_POS;
                    end else begin
                        res_next = sum;
                    end
                end
                rpn_pkg::OP_SUB: begin
                    res_ok_next = 1'b1;
                    if (a_reg[63] != b_reg[63] && dif[63] != a_reg[63]) begin
                        flags_next[2] = 1'b1;
                        res_next = a_reg[63] ? rpn_pkg::MIN_NEG : rpn_pkg::MAX_POS;
                    end else begin
                        res_next = dif;
                    end
                end
                rpn_pkg::OP_MIN: begin
                    res_ok_next = 1'b1;
                    res_next = a_lt_b ? a_reg : b_reg;
                end
                rpn_pkg::OP_MAX: begin
                    res_ok_next = 1'b1;
                    res_next = a_lt_b ? b_reg : a_reg;
                end
                default: begin
                end
            endcase
        end
        if (mul_busy_reg && mul_ph_reg == 2'd2) begin
            res_ok_next = 1'b1;
            if (neg_res) begin
                if (mbig || mag > rpn_pkg::MIN_NEG) begin
                    flags_next[2] = 1'b1;
                    res_next = rpn_pkg::MIN_NEG;
                end else begin
                    res_next = 64'd0 - mag;
                end
            end else if (mbig || mag > rpn_pkg::MAX_POS) begin
                flags_next[2] = 1'b1;
                res_next = rpn_pkg::MAX_POS;
            end else begin
                res_next = mag;
            end
        end
        if (div_done) begin
            res_ok_next = 1'b1;
            if (item_reg.op == rpn_pkg::OP_MOD) begin
                res_next = a_reg[63] ? (64'd0 - div_r) : div_r;
            end else if (neg_res) begin
                if (div_big || div_q > rpn_pkg::MIN_NEG) begin
                    flags_next[2] = 1'b1;
                    res_next = rpn_pkg::MIN_NEG;
                end else begin
                    res_next = 64'd0 - div_q;
                end
            end else if (div_big || div_q > rpn_pkg::MAX_POS) begin
                flags_next[2] = 1'b1;
                res_next = rpn_pkg::MAX_POS;
            end else begin
                res_next = div_q;
            end
        end
        if (cmd.skip_div) begin
            flags_next[0] = 1'b1;
            res_next = '0;
        end
        if (cmd.push && cnt_reg == rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH)) begin
            flags_next[1] = 1'b1;
        end
        if (cmd.emit) begin
            flags_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            flags_reg    <= '0;
            ovalid_reg   <= 1'b0;
            mul_busy_reg <= 1'b0;
            mul_ph_reg   <= '0;
            res_ok_reg   <= 1'b0;
            lda_reg      <= 1'b0;
        end else begin
            flags_reg  <= flags_next;
            res_ok_reg <= res_ok_next;
            lda_reg    <= cmd.rd_a;
            if (cmd.emit) begin
                cnt_reg <= '0;
            end else if (cmd.push && cnt_reg != rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH)) begin
                cnt_reg <= cnt_reg + rpn_pkg::CNT_W'(1);
            end else if (cmd.writeback) begin
                cnt_reg <= cnt_reg - rpn_pkg::CNT_W'(1);
            end
            if (cmd.emit) begin
                ovalid_reg <= 1'b1;
            end else if (out_ready) begin
                ovalid_reg <= 1'b0;
            end
            if (cmd.alu_start && item_reg.op == rpn_pkg::OP_MUL) begin
                mul_busy_reg <= 1'b1;
                mul_ph_reg   <= '0;
            end else if (mul_busy_reg) begin
                mul_ph_reg <= mul_ph_reg + 2'd1;
                if (mul_ph_reg == 2'd2) begin
                    mul_busy_reg <= 1'b0;
                end
            end
        end
        if (cmd.load_item) begin
            item_reg <= in_item;
        end
        if (cmd.rd_a) begin
            b_reg <= rd_data_reg;
        end
        if (lda_reg) begin
            a_reg <= rd_data_reg;
        end
        res_reg <= res_next;
        if (cmd.alu_start) begin
            am_reg <= a_mag;
            bm_reg <= b_mag;
        end
        if (mul_busy_reg && mul_ph_reg == 2'd0) begin
            p00_reg <= {32'd0, am_reg[31:0]} * {32'd0, bm_reg[31:0]};
            p01_reg <= {32'd0, am_reg[31:0]} * {32'd0, bm_reg[63:32]};
            p10_reg <= {32'd0, am_reg[63:32]} * {32'd0, bm_reg[31:0]};
            p11_reg <= {32'd0, am_reg[63:32]} * {32'd0, bm_reg[63:32]};
        end
        if (cmd.emit) begin
            oitem_reg.result           <= (cnt_reg != '0) ? $signed(rd_data_reg) : 64'sd0;
            oitem_reg.divided_by_zero  <= flags_reg[0];
            oitem_reg.stack_overflowed <= flags_reg[1];
            oitem_reg.saturated        <= flags_reg[2];
        end
    end

    assign sts.op       = item_reg.op;
    assign sts.last     = item_reg.last;
    assign sts.full     = cnt_reg == rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH);
    assign sts.two_plus = cnt_reg >= rpn_pkg::CNT_W'(2);
    assign sts.b_zero   = b_reg == 64'd0;
    assign sts.alu_done = res_ok_reg;
    assign sts.out_busy = ovalid_reg && !out_ready;

    assign out_item  = oitem_reg;
    assign out_valid = ovalid_reg;

endmodule

// File: design/rpn_controller.sv
// ----------------------------------------------------------------------------
// rpn_controller
// Sequences one transaction: stack reads, operation, write-back and emit.
// ----------------------------------------------------------------------------
module rpn_controller (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  rpn_pkg::dp_sts_t sts,
    output rpn_pkg::dp_cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_RDB   = 4'd2;
    localparam logic [3:0] S_RDA   = 4'd3;
    localparam logic [3:0] S_EXEC  = 4'd5;
    localparam logic [3:0] S_WAIT  = 4'd6;
    localparam logic [3:0] S_WB    = 4'd7;
    localparam logic [3:0] S_TOP   = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;
    localparam logic [3:0] S_LAST  = 4'd10;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_item = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                if (sts.op == rpn_pkg::OP_PUSH) begin
                    cmd.push = 1'b1;
                    state_next = S_LAST;
                end else if (sts.two_plus) begin
                    cmd.rd_b = 1'b1;
                    state_next = S_RDB;
                end else begin
                    state_next = S_LAST;
                end
            end
            S_RDB: begin
                cmd.rd_a = 1'b1;
                state_next = S_RDA;
            end
            S_RDA: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if ((sts.op == rpn_pkg::OP_DIV || sts.op == rpn_pkg::OP_MOD) && sts.b_zero) begin
                    cmd.skip_div = 1'b1;
                    state_next = S_WB;
                end else begin
                    cmd.alu_start = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (sts.alu_done) begin
                    state_next = S_WB;
                end
            end
            S_WB: begin
                cmd.writeback = 1'b1;
                state_next = S_LAST;
            end
            S_LAST: begin
                if (sts.last) begin
                    cmd.rd_b = 1'b1;
                    state_next = S_TOP;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_TOP: begin
                cmd.rd_b = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                cmd.rd_b = 1'b1;
                if (!sts.out_busy) begin
                    cmd.emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/rpn_stack_evaluator_core.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_core
// Postfix evaluator in signed Q32.32 with a 16-entry operand stack.
//
// Channel   Ports                     Payload
// input     s_valid / s_ready         s_item  (op, value, last)
// result    m_valid / m_ready         m_item  (result, three flags)
//
// A push, or an operator with fewer than two stack entries, ends after decode;
// other operators read two entries, operate and write back, divide and mod
// on the radix-2 divider unless the divisor is zero. The last transaction also
// loads the output register, after any wait for the previous result.
// Reset is synchronous and active low; the stack needs no clearing.
// A stalled result holds only the final transaction of the next program.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rpn_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output rpn_pkg::out_item_t m_item
);

    rpn_pkg::dp_cmd_t cmd;
    rpn_pkg::dp_sts_t sts;

    rpn_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rpn_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_item   (s_item),
        .cmd       (cmd),
        .sts       (sts),
        .out_item  (m_item),
        .out_valid (m_valid),
        .out_ready (m_ready)
    );

endmodule

// File: sim/rpn_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_result_checker
// Watches both channels of the RPN evaluator, keeps its own copy of the
// operand stack and flags, predicts each program result and compares it.
// ----------------------------------------------------------------------------
module rpn_result_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  rpn_pkg::in_item_t  s_item,
    input  logic               m_valid,
    input  logic               m_ready,
    input  rpn_pkg::out_item_t m_item,
    output int                 error_count,
    output int                 pending_count,
    output int                 result_count
);

    logic [63:0]        model_stack [rpn_pkg::STACK_DEPTH];
    int                 model_depth;
    logic               flag_div0;
    logic               flag_ovf;
    logic               flag_sat;
    rpn_pkg::out_item_t expected_results [$];

    assign pending_count = expected_results.size();

    function automatic logic [63:0] clamp_signed(logic [63:0] mag, logic neg, logic big);
        if (neg) begin
            if (big || mag > rpn_pkg::MIN_NEG) begin
                flag_sat = 1'b1;
                return rpn_pkg::MIN_NEG;
            end
            return -mag;
        end
        if (big || mag > rpn_pkg::MAX_POS) begin
            flag_sat = 1'b1;
            return rpn_pkg::MAX_POS;
        end
        return mag;
    endfunction

    function automatic logic [63:0] magn(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] apply_operator(logic [2:0] op, logic [63:0] a,
                                                   logic [63:0] b);
        logic [63:0]  r;
        logic [127:0] prod;
        logic [127:0] quo;
        case (op)
            rpn_pkg::OP_ADD: begin
                r = a + b;
                if (a[63] == b[63] && r[63] != a[63]) begin
                    flag_sat = 1'b1;
                    r = a[63] ? rpn_pkg::MIN_NEG : rpn_pkg::MAX_POS;
                end
            end
            rpn_pkg::OP_SUB: begin
                r = a - b;
                if (a[63] != b[63] && r[63] != a[63]) begin
                    flag_sat = 1'b1;
                    r = a[63] ? rpn_pkg::MIN_NEG : rpn_pkg::MAX_POS;
                end
            end
            rpn_pkg::OP_MUL: begin
                prod = {64'd0, magn(a)} * {64'd0, magn(b)};
                r = clamp_signed(prod[95:32], a[63] ^ b[63], prod[127:96] != 0);
            end
            rpn_pkg::OP_DIV, rpn_pkg::OP_MOD: begin
                if (b == 0) begin
                    flag_div0 = 1'b1;
                    r = '0;
                end else if (op == rpn_pkg::OP_DIV) begin
                    quo = {32'd0, magn(a), 32'd0} / {64'd0, magn(b)};
                    r = clamp_signed(quo[63:0], a[63] ^ b[63], quo[127:64] != 0);
                end else begin
                    r = magn(a) % magn(b);
                    if (a[63]) r = -r;
                end
            end
            rpn_pkg::OP_MIN: r = ($signed(b) < $signed(a)) ? b : a;
            default: r = ($signed(a) < $signed(b)) ? b : a;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        rpn_pkg::out_item_t want;
        if (!aresetn) begin
            model_depth  <= 0;
            flag_div0    = 1'b0;
            flag_ovf     = 1'b0;
            flag_sat     = 1'b0;
            error_count  <= 0;
            result_count <= 0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: result transaction with none expected: %p", $time, m_item);
                    error_count <= error_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== m_item) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, m_item);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                int d;
                d = model_depth;
                if (s_item.op == rpn_pkg::OP_PUSH) begin
                    if (d < rpn_pkg::STACK_DEPTH) begin
                        model_stack[d] = s_item.value;
                        d++;
                    end else begin
                        flag_ovf = 1'b1;
                    end
                end else if (d >= 2) begin
                    model_stack[d-2] = apply_operator(s_item.op, model_stack[d-2],
                                                      model_stack[d-1]);
                    d--;
                end
                if (s_item.last) begin
                    want.result           = (d > 0) ? model_stack[d-1] : 64'd0;
                    want.divided_by_zero  = flag_div0;
                    want.stack_overflowed = flag_ovf;
                    want.saturated        = flag_sat;
                    expected_results = {expected_results, want};
                    d = 0;
                    flag_div0 = 1'b0;
                    flag_ovf  = 1'b0;
                    flag_sat  = 1'b0;
                end
                model_depth <= d;
            end
        end
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random postfix programs into the RPN evaluator under
// three idling regimes; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int IDLE_LIMIT = 20000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    rpn_pkg::in_item_t  s_item = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    rpn_pkg::out_item_t m_item;
    int                 error_count;
    int                 pending_count;
    int                 result_count;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 atom_count = 0;
    int                 idle_cycles = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    rpn_stack_evaluator_core i_dut (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_item(s_item), .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    rpn_result_checker i_checker (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_item(s_item), .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .error_count(error_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    always @(posedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired at %0t", $time);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] pick_value();
        case ($urandom_range(9))
            0: return rpn_pkg::MIN_NEG;
            1: return rpn_pkg::MAX_POS;
            2: return 64'd0;
            3: return {{32{1'b0}}, $urandom()} << $urandom_range(40);
            4: return -({32'd0, $urandom()} << $urandom_range(40));
            5: return {$urandom_range(7) == 0 ? 32'hFFFF_FFFF : 32'd0, $urandom()};
            6: return $signed({$urandom_range(200), 32'd0}) - (64'd100 << 32);
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic send_atom(logic [2:0] op, logic [63:0] value, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_item.op    <= op;
        s_item.value <= value;
        s_item.last  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        atom_count++;
    endtask

    task automatic send_program();
        int len;
        int depth;
        logic [2:0] op;
        len = ($urandom_range(19) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 9);
        depth = 0;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0) op = 3'($urandom_range(7));
            else if (depth < 2) op = rpn_pkg::OP_PUSH;
            else if ($urandom_range(1) != 0) op = rpn_pkg::OP_PUSH;
            else op = 3'($urandom_range(1, 7));
            if (op == rpn_pkg::OP_PUSH) depth++;
            else if (depth >= 2) depth--;
            send_atom(op, ($urandom_range(5) == 0 && op != rpn_pkg::OP_PUSH) ? 64'd0
                                                                           : pick_value(),
                      i == len - 1);
        end
    endtask

    task automatic binary_case(logic [2:0] op, logic [63:0] a, logic [63:0] b);
        send_atom(rpn_pkg::OP_PUSH, a, 1'b0);
        send_atom(rpn_pkg::OP_PUSH, b, 1'b0);
        send_atom(op, {$urandom(), $urandom()}, 1'b1);
    endtask

    initial begin
        send_idle_pct = 15;
        recv_idle_pct = 50;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_atom(rpn_pkg::OP_PUSH, 64'd0, 1'b1);
        send_atom(rpn_pkg::OP_ADD, 64'd5, 1'b1);
        binary_case(rpn_pkg::OP_ADD, rpn_pkg::MAX_POS, 64'd1);
        binary_case(rpn_pkg::OP_SUB, rpn_pkg::MIN_NEG, 64'd1);
        binary_case(rpn_pkg::OP_MUL, rpn_pkg::MAX_POS, rpn_pkg::MIN_NEG);
        binary_case(rpn_pkg::OP_DIV, rpn_pkg::MIN_NEG, 64'hFFFF_FFFF_FFFF_FFFF);
        binary_case(rpn_pkg::OP_DIV, 64'd7 << 32, 64'd0);
        binary_case(rpn_pkg::OP_MOD, -(64'd7 << 32), 64'd3 << 32);
        binary_case(rpn_pkg::OP_MIN, rpn_pkg::MIN_NEG, rpn_pkg::MAX_POS);
        binary_case(rpn_pkg::OP_MAX, rpn_pkg::MIN_NEG, rpn_pkg::MAX_POS);
        for (int i = 0; i <= rpn_pkg::STACK_DEPTH; i++)
            send_atom(rpn_pkg::OP_PUSH, 64'(i), i == rpn_pkg::STACK_DEPTH);

        while (atom_count < 1800) begin
            if (atom_count > 600 && send_idle_pct == 15) begin
                send_idle_pct = 50;
                recv_idle_pct = 15;
            end else if (atom_count > 1200 && send_idle_pct == 50) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_program();
        end
        s_valid <= 1'b0;

        while (pending_count != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
        $display("Sent %0d atoms; checked %0d program results across three idling regimes.",
                 atom_count, result_count);
        if (error_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
